### rtl/smpd_pkg.sv
package smpd_pkg;

   localparam int unsigned POS_W   = 15;
   localparam int unsigned BYTE_W  = 7;
   localparam int unsigned LOW6_W  = 6;

   localparam logic [POS_W-1:0] LIMIT_RESET = 15'd4096;

   // Header byte layout
   localparam int unsigned SYNC_BIT  = 6;
   localparam int unsigned LEFT_BIT  = 5;
   localparam int unsigned RIGHT_BIT = 4;

   typedef enum logic [1:0] {
      STATUS_DONE     = 2'd0,
      STATUS_SYNC_ERR = 2'd1,
      STATUS_LINE_ERR = 2'd2
   } status_type;

   typedef struct packed {
      status_type       status;
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] pos_y;
      logic             left_button;
      logic             right_button;
   } rsp_type;

   // Add a signed 8-bit delta to a position and clamp to 0..limit.
   function automatic logic [POS_W-1:0] move_clamp(input logic [POS_W-1:0] pos,
                                                   input logic [7:0]       delta,
                                                   input logic [POS_W-1:0] limit);
      logic signed [POS_W+1:0] sum;
      logic [POS_W-1:0]        res;
      sum = $signed({2'b00, pos}) + $signed({{(POS_W-6){delta[7]}}, delta});
      if (sum[POS_W+1]) begin
         res = '0;
      end else if (sum[POS_W:0] > {1'b0, limit}) begin
         res = limit;
      end else begin
         res = sum[POS_W-1:0];
      end
      return res;
   endfunction

endpackage

### rtl/serial_mouse_packet_decoder.sv
// Serial mouse packet decoder. Takes one received 7-bit byte per item (with a
// line-error flag) and assembles three-byte packets: a header with bit 6 set,
// then the low six bits of the X delta, then those of the Y delta. The header
// supplies the buttons and the two top bits of each 8-bit signed delta. On the
// third byte the deltas are added to the X/Y positions, each clamped to
// 0..position_limit, and a result item with status "done" is sent. A header
// byte missing its sync bit is dropped with a "sync error" result; any byte
// flagged with a line error aborts the packet with a "line error" result.
// Both error results carry the unchanged positions and buttons. Header and X
// bytes give no result. Rate: one item per clock while req_stall is low. The
// whole decode/accumulate/clamp step is done in the accept cycle; the result
// is registered in the result register, or in the skid entry if an older
// result waits, and shows on rsp_*. A one-entry skid buffer behind the result
// register lets input keep flowing while a result waits; req_stall rises
// only once that skid entry is also occupied. position_limit is written
// through csr_* (always ready) and takes effect at the next completed packet;
// stored positions above a newly lowered limit are reported as-is until then.
module serial_mouse_packet_decoder (
   input  logic                            clock,
   input  logic                            reset,
   // byte input channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [smpd_pkg::BYTE_W-1:0]     req_rx_byte,
   input  logic                            req_line_error,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_status,
   output logic [smpd_pkg::POS_W-1:0]      rsp_pos_x,
   output logic [smpd_pkg::POS_W-1:0]      rsp_pos_y,
   output logic                            rsp_left_button,
   output logic                            rsp_right_button,
   // position limit register
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [smpd_pkg::POS_W-1:0]      csr_position_limit
);

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_X      = 2'd1,
      PH_Y      = 2'd2
   } phase_type;

   // packet state
   phase_type                        phase_ff,  phase_in;
   logic [smpd_pkg::LOW6_W-1:0]      header_ff, header_in;
   logic [smpd_pkg::LOW6_W-1:0]      x_low_ff,  x_low_in;
   logic [smpd_pkg::POS_W-1:0]       pos_x_ff,  pos_x_in;
   logic [smpd_pkg::POS_W-1:0]       pos_y_ff,  pos_y_in;
   logic                             left_ff,   left_in;
   logic                             right_ff,  right_in;
   logic [smpd_pkg::POS_W-1:0]       limit_ff,  limit_in;

   // result register and skid entry
   logic                             out_valid_ff,  out_valid_in;
   smpd_pkg::rsp_type                out_ff,        out_in;
   logic                             skid_valid_ff, skid_valid_in;
   smpd_pkg::rsp_type                skid_ff,       skid_in;

   logic                             accept;
   logic                             gen;
   smpd_pkg::rsp_type                res;
   logic                             out_free;
   logic [7:0]                       dx;
   logic [7:0]                       dy;

   assign req_stall = skid_valid_ff;
   assign csr_ready = 1'b1;
   assign accept    = req_valid && !req_stall;
   assign out_free  = !out_valid_ff || !rsp_stall;

   // rebuilt 8-bit deltas; Y low bits come straight from the current byte
   assign dx = {header_ff[1:0], x_low_ff};
   assign dy = {header_ff[3:2], req_rx_byte[smpd_pkg::LOW6_W-1:0]};

   // decode one byte
   always_comb begin
      phase_in  = phase_ff;
      header_in = header_ff;
      x_low_in  = x_low_ff;
      pos_x_in  = pos_x_ff;
      pos_y_in  = pos_y_ff;
      left_in   = left_ff;
      right_in  = right_ff;
      gen       = 1'b0;
      res.status = smpd_pkg::STATUS_DONE;

      if (accept) begin
         if (req_line_error) begin
            phase_in   = PH_HEADER;
            gen        = 1'b1;
            res.status = smpd_pkg::STATUS_LINE_ERR;
         end else begin
            case (phase_ff)
               PH_X: begin
                  x_low_in = req_rx_byte[smpd_pkg::LOW6_W-1:0];
                  phase_in = PH_Y;
               end
               PH_Y: begin
                  pos_x_in   = smpd_pkg::move_clamp(pos_x_ff, dx, limit_ff);
                  pos_y_in   = smpd_pkg::move_clamp(pos_y_ff, dy, limit_ff);
                  left_in    = header_ff[smpd_pkg::LEFT_BIT];
                  right_in   = header_ff[smpd_pkg::RIGHT_BIT];
                  phase_in   = PH_HEADER;
                  gen        = 1'b1;
                  res.status = smpd_pkg::STATUS_DONE;
               end
               default: begin
                  // header phase (unused code treated the same)
                  if (!req_rx_byte[smpd_pkg::SYNC_BIT]) begin
                     phase_in   = PH_HEADER;
                     gen        = 1'b1;
                     res.status = smpd_pkg::STATUS_SYNC_ERR;
                  end else begin
                     header_in = req_rx_byte[smpd_pkg::LOW6_W-1:0];
                     phase_in  = PH_X;
                  end
               end
            endcase
         end
      end

      res.pos_x        = pos_x_in;
      res.pos_y        = pos_y_in;
      res.left_button  = left_in;
      res.right_button = right_in;
   end

   // config write
   assign limit_in = (csr_valid && csr_ready) ? csr_position_limit : limit_ff;

   // result register / skid steering; skid is always older than a new result
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = gen;
            skid_in       = res;
         end else begin
            out_valid_in = gen;
            out_in       = res;
         end
      end else if (gen) begin
         skid_valid_in = 1'b1;
         skid_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEADER;
         header_ff     <= '0;
         x_low_ff      <= '0;
         pos_x_ff      <= '0;
         pos_y_ff      <= '0;
         left_ff       <= 1'b0;
         right_ff      <= 1'b0;
         limit_ff      <= smpd_pkg::LIMIT_RESET;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         header_ff     <= header_in;
         x_low_ff      <= x_low_in;
         pos_x_ff      <= pos_x_in;
         pos_y_ff      <= pos_y_in;
         left_ff       <= left_in;
         right_ff      <= right_in;
         limit_ff      <= limit_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_status       = out_ff.status;
   assign rsp_pos_x        = out_ff.pos_x;
   assign rsp_pos_y        = out_ff.pos_y;
   assign rsp_left_button  = out_ff.left_button;
   assign rsp_right_button = out_ff.right_button;

endmodule
